>>> src/dlp_pkg.sv
// shared types, codes and constants of the descriptor loop parser
// no dependencies; used by every module of the block
package dlp_pkg;

  localparam logic [7:0] PRIVATE_TAG_MIN = 8'h80;
  localparam int unsigned LOOP_LEN_W = 12;
  localparam int unsigned AREA_W = 13;
  localparam logic [2:0] SPEC_BYTES = 3'd4;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the configuration registers
  localparam logic RST_HEADER_MODE = 1'b0;
  localparam logic [7:0] RST_SPECIFIER_TAG = 8'd95;
  localparam logic [7:0] RST_MATCH_TAG = 8'd0;
  localparam logic [31:0] RST_MATCH_SPECIFIER = 32'd0;

  // depth of the event queue between the parser and the result stage
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_MODE     = 2'd0,
    CFG_SPECIFIER_TAG   = 2'd1,
    CFG_MATCH_TAG       = 2'd2,
    CFG_MATCH_SPECIFIER = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR1      = 3'd1,
    PH_HDR2      = 3'd2,
    PH_TAG       = 3'd3,
    PH_LEN       = 3'd4,
    PH_PAY       = 3'd5,
    PH_SKIP_PART = 3'd6,
    PH_SKIP_OVER = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_HDR_TRUNC = 2'd2,
    ST_LOOP_OVER = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DESC   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    logic        header_mode;
    logic [7:0]  specifier_tag;
    logic [7:0]  match_tag;
    logic [31:0] match_specifier;
  } cfg_t;

  // what one input byte leaves for the result stage
  typedef struct packed {
    logic        has_desc;
    logic [7:0]  tag;
    logic [7:0]  length;
    logic [31:0] spec;
    logic        has_status;
    status_e     status;
  } event_t;

endpackage

>>> src/dlp_if.sv
// valid/ready channels of the descriptor loop parser: byte input and result output
// no dependencies; the status field is a plain two-bit code
interface dlp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        area_start;
  logic [12:0] area_size;
  logic        new_list;

  modport source (output valid, data_byte, area_start, area_size, new_list, input ready);
  modport sink (input valid, data_byte, area_start, area_size, new_list, output ready);
endinterface

interface dlp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tag;
  logic [7:0]  payload_length;
  logic [31:0] specifier;
  logic        tag_match;
  logic        orphan_private;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, tag, payload_length, specifier, tag_match,
                  orphan_private, status, last, input ready);
  modport sink (input valid, kind, tag, payload_length, specifier, tag_match,
                orphan_private, status, last, output ready);
endinterface

>>> src/dlp_front.sv
// front end: accepts area bytes, walks the tag-length-payload structure and
// tracks the private data specifier; depends on dlp_pkg and dlp_in_if
module dlp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dlp_pkg::cfg_t     cfg_i,
  dlp_in_if.sink            in_i,
  input  logic              full_i,
  output logic              push_o,
  output dlp_pkg::event_t   event_o
);

  dlp_pkg::phase_e phase_q, phase_d;
  logic [dlp_pkg::AREA_W-1:0] area_q, area_d;
  logic [dlp_pkg::AREA_W-1:0] loop_q, loop_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pay_q, pay_d;
  logic [31:0] coll_q, coll_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] cur_q, cur_d;

  logic fire;
  logic run;
  logic [dlp_pkg::AREA_W-1:0] size_eff;
  logic [dlp_pkg::AREA_W-1:0] rest;
  logic [dlp_pkg::LOOP_LEN_W-1:0] hdr_len;
  logic [31:0] desc_spec;
  dlp_pkg::event_t ev;

  assign in_i.ready = !full_i;
  assign fire = in_i.valid && in_i.ready;
  assign push_o = fire && (ev.has_desc || ev.has_status);
  assign event_o = ev;

  always_comb begin
    phase_d = phase_q;
    area_d = area_q;
    loop_d = loop_q;
    tag_d = tag_q;
    len_d = len_q;
    pay_d = pay_q;
    coll_d = coll_q;
    cnt_d = cnt_q;
    cur_d = cur_q;
    ev = '0;
    ev.status = dlp_pkg::ST_OK;
    size_eff = '0;
    rest = '0;
    hdr_len = '0;
    desc_spec = '0;
    run = 1'b0;

    if (fire) begin
      run = 1'b1;
      if (in_i.area_start) begin
        if (in_i.new_list) begin
          cur_d = '0;
        end
        size_eff = (in_i.area_size == '0) ? dlp_pkg::AREA_W'(1) : in_i.area_size;
        area_d = size_eff;
        if (cfg_i.header_mode) begin
          if (size_eff < dlp_pkg::AREA_W'(2)) begin
            // no room for the length field: reject at once
            area_d = '0;
            phase_d = dlp_pkg::PH_IDLE;
            ev.has_status = 1'b1;
            ev.status = dlp_pkg::ST_HDR_TRUNC;
            run = 1'b0;
          end else begin
            loop_d = '0;
            phase_d = dlp_pkg::PH_HDR1;
          end
        end else begin
          loop_d = size_eff;
          phase_d = dlp_pkg::PH_TAG;
        end
      end else if (phase_q == dlp_pkg::PH_IDLE) begin
        run = 1'b0;
      end
    end

    if (run) begin
      unique case (phase_d)
        dlp_pkg::PH_HDR1: begin
          loop_d = {1'b0, in_i.data_byte[3:0], 8'h00};
          phase_d = dlp_pkg::PH_HDR2;
        end
        dlp_pkg::PH_HDR2: begin
          hdr_len = {loop_d[11:8], in_i.data_byte};
          rest = (area_d != '0) ? area_d - dlp_pkg::AREA_W'(1) : '0;
          if ({1'b0, hdr_len} > rest) begin
            loop_d = '0;
            phase_d = dlp_pkg::PH_SKIP_OVER;
          end else begin
            loop_d = {1'b0, hdr_len};
            phase_d = dlp_pkg::PH_TAG;
          end
        end
        dlp_pkg::PH_TAG: begin
          if (loop_d == '0) begin
            // past the loop: byte is dropped
          end else if (loop_d == dlp_pkg::AREA_W'(1)) begin
            loop_d = '0;
            phase_d = dlp_pkg::PH_SKIP_PART;
          end else begin
            tag_d = in_i.data_byte;
            loop_d = loop_d - dlp_pkg::AREA_W'(1);
            phase_d = dlp_pkg::PH_LEN;
          end
        end
        dlp_pkg::PH_LEN: begin
          if (loop_d != '0) begin
            loop_d = loop_d - dlp_pkg::AREA_W'(1);
          end
          len_d = in_i.data_byte;
          coll_d = '0;
          cnt_d = '0;
          if ({5'b0, in_i.data_byte} > loop_d) begin
            loop_d = '0;
            phase_d = dlp_pkg::PH_SKIP_PART;
          end else if (in_i.data_byte == 8'h00) begin
            ev.has_desc = 1'b1;
            phase_d = dlp_pkg::PH_TAG;
          end else begin
            pay_d = in_i.data_byte;
            phase_d = dlp_pkg::PH_PAY;
          end
        end
        dlp_pkg::PH_PAY: begin
          if (loop_d != '0) begin
            loop_d = loop_d - dlp_pkg::AREA_W'(1);
          end
          if (cnt_d < dlp_pkg::SPEC_BYTES) begin
            coll_d = {coll_d[23:0], in_i.data_byte};
            cnt_d = cnt_d + 3'd1;
          end
          if (pay_d != 8'h00) begin
            pay_d = pay_d - 8'd1;
          end
          if (pay_d == 8'h00) begin
            ev.has_desc = 1'b1;
            phase_d = dlp_pkg::PH_TAG;
          end
        end
        default: begin
        end
      endcase

      if (ev.has_desc) begin
        // a specifier descriptor replaces the current specifier
        if (tag_d == cfg_i.specifier_tag) begin
          desc_spec = (cnt_d >= dlp_pkg::SPEC_BYTES) ? coll_d : '0;
          cur_d = desc_spec;
        end else begin
          desc_spec = cur_d;
        end
        ev.tag = tag_d;
        ev.length = len_d;
        ev.spec = desc_spec;
      end

      if (area_d != '0) begin
        area_d = area_d - dlp_pkg::AREA_W'(1);
      end
      if (area_d == '0) begin
        ev.has_status = 1'b1;
        if (phase_d == dlp_pkg::PH_SKIP_OVER) begin
          ev.status = dlp_pkg::ST_LOOP_OVER;
        end else if (phase_d == dlp_pkg::PH_TAG && loop_d == '0) begin
          ev.status = dlp_pkg::ST_OK;
        end else begin
          ev.status = dlp_pkg::ST_PARTIAL;
        end
        phase_d = dlp_pkg::PH_IDLE;
        loop_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dlp_pkg::PH_IDLE;
      area_q <= '0;
      loop_q <= '0;
      tag_q <= '0;
      len_q <= '0;
      pay_q <= '0;
      coll_q <= '0;
      cnt_q <= '0;
      cur_q <= '0;
    end else begin
      phase_q <= phase_d;
      area_q <= area_d;
      loop_q <= loop_d;
      tag_q <= tag_d;
      len_q <= len_d;
      pay_q <= pay_d;
      coll_q <= coll_d;
      cnt_q <= cnt_d;
      cur_q <= cur_d;
    end
  end

  a_idle_no_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dlp_pkg::PH_IDLE |-> area_q == '0)
    else $error("idle parser with bytes left in area");

  a_collect_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dlp_pkg::SPEC_BYTES)
    else $error("specifier collect count overrun");

endmodule

>>> src/dlp_queue.sv
// short event queue between the parser front end and the result stage
// flop-based ring of dlp_pkg::QDEPTH entries; depends on dlp_pkg
module dlp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dlp_pkg::event_t push_data_i,
  input  logic            pop_i,
  output dlp_pkg::event_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  dlp_pkg::event_t mem_q [dlp_pkg::QDEPTH];
  logic [dlp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [dlp_pkg::QCNT_W-1:0] count_q;

  function automatic logic [dlp_pkg::QPTR_W-1:0] ptr_inc(
    input logic [dlp_pkg::QPTR_W-1:0] ptr
  );
    return (ptr == dlp_pkg::QPTR_W'(dlp_pkg::QDEPTH - 1)) ? '0 : ptr + dlp_pkg::QPTR_W'(1);
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == dlp_pkg::QCNT_W'(dlp_pkg::QDEPTH));
  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + dlp_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - dlp_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full event queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty event queue");

endmodule

>>> src/dlp_back.sv
// result stage: turns queued events into descriptor and status results,
// evaluates the search match; depends on dlp_pkg and dlp_out_if
module dlp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dlp_pkg::cfg_t   cfg_i,
  input  dlp_pkg::event_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  dlp_out_if.source       out_o
);

  logic sent_q, sent_d;
  logic show_desc;
  logic final_res;
  logic fire;
  logic check;

  assign show_desc = head_i.has_desc && !sent_q;
  assign final_res = !show_desc || !head_i.has_status;
  assign fire = out_o.valid && out_o.ready;
  assign pop_o = fire && final_res;

  // specifier only checked for a private match tag with a nonzero specifier
  assign check = (cfg_i.match_specifier != '0) && (cfg_i.match_tag >= dlp_pkg::PRIVATE_TAG_MIN);

  always_comb begin
    out_o.valid = !empty_i;
    out_o.last = final_res;
    out_o.kind = dlp_pkg::KIND_STATUS;
    out_o.tag = '0;
    out_o.payload_length = '0;
    out_o.specifier = '0;
    out_o.tag_match = 1'b0;
    out_o.orphan_private = 1'b0;
    out_o.status = head_i.status;
    if (show_desc) begin
      out_o.kind = dlp_pkg::KIND_DESC;
      out_o.tag = head_i.tag;
      out_o.payload_length = head_i.length;
      out_o.specifier = head_i.spec;
      out_o.tag_match = (head_i.tag == cfg_i.match_tag) &&
                        (!check || head_i.spec == cfg_i.match_specifier);
      out_o.orphan_private = (head_i.tag >= dlp_pkg::PRIVATE_TAG_MIN) && (head_i.spec == '0);
      out_o.status = dlp_pkg::ST_OK;
    end
  end

  always_comb begin
    sent_d = sent_q;
    if (pop_o) begin
      sent_d = 1'b0;
    end else if (fire) begin
      sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= 1'b0;
    end else begin
      sent_q <= sent_d;
    end
  end

  a_sent_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> (!empty_i && head_i.has_desc && head_i.has_status))
    else $error("descriptor marked sent without a pending status");

  a_event_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (head_i.has_desc || head_i.has_status))
    else $error("queued event carries no result");

endmodule

>>> src/descriptor_loop_parser_unit.sv
// a byte's event is registered in the event queue before its result is offered
// throughput: one byte per cycle while the event queue is not full; a byte that ends
//   a descriptor and its area gives two results, and the three-entry queue absorbs it
// reset: asynchronous, active low; parser idle, specifier zero, registers at defaults
// holds the configuration registers and ties front end, queue and result stage
// depends on dlp_pkg, dlp_if, dlp_front, dlp_queue, dlp_back
module descriptor_loop_parser_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  dlp_in_if.sink                                in_i,
  dlp_out_if.source                             out_o,
  input  logic                                  cfg_we_i,
  input  logic [dlp_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [dlp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  dlp_pkg::cfg_t   cfg_q;
  dlp_pkg::event_t ev;
  dlp_pkg::event_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_mode <= dlp_pkg::RST_HEADER_MODE;
      cfg_q.specifier_tag <= dlp_pkg::RST_SPECIFIER_TAG;
      cfg_q.match_tag <= dlp_pkg::RST_MATCH_TAG;
      cfg_q.match_specifier <= dlp_pkg::RST_MATCH_SPECIFIER;
    end else if (cfg_we_i) begin
      unique case (dlp_pkg::cfg_index_e'(cfg_index_i))
        dlp_pkg::CFG_HEADER_MODE:     cfg_q.header_mode <= cfg_data_i[0];
        dlp_pkg::CFG_SPECIFIER_TAG:   cfg_q.specifier_tag <= cfg_data_i[7:0];
        dlp_pkg::CFG_MATCH_TAG:       cfg_q.match_tag <= cfg_data_i[7:0];
        dlp_pkg::CFG_MATCH_SPECIFIER: cfg_q.match_specifier <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  dlp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .event_o (ev)
  );

  dlp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (ev),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  dlp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> verif/dlp_result_checker.sv
// result checker for the descriptor loop parser: watches the byte and result channels and
// the config port, predicts every result item and compares; depends on dlp_pkg and dlp_if
`timescale 1ns / 1ps
module dlp_result_checker
  import dlp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dlp_in_if                      in_mon_i,
  dlp_out_if                     out_mon_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [7:0]  plen;
    logic [31:0] spec;
    logic        hit;
    logic        orphan;
    status_e     status;
    logic        last;
  } parse_result_t;

  parse_result_t expected_q[$];
  parse_result_t step_q[$];
  int fails = 0;

  // shadow registers
  logic        hdr_mode;
  logic [7:0]  spec_tag;
  logic [7:0]  want_tag;
  logic [31:0] want_spec;

  // parser state
  logic [31:0] cur_spec;
  phase_e      phase;
  logic [12:0] area_left;
  logic [12:0] loop_left;
  logic [7:0]  held_tag;
  logic [7:0]  held_len;
  logic [7:0]  pay_left;
  logic [31:0] collect;
  logic [2:0]  collect_n;

  function automatic string fmt_result(parse_result_t r);
    return $sformatf("kind %0d tag %02h len %0d spec %08h match %0b orphan %0b status %0d last %0b",
                     r.kind, r.tag, r.plen, r.spec, r.hit, r.orphan, r.status, r.last);
  endfunction

  task emit_descriptor();
    logic [31:0]   spec;
    logic          checked;
    parse_result_t r;
    if (held_tag == spec_tag) begin
      spec = (collect_n >= SPEC_BYTES) ? collect : '0;
      cur_spec = spec;
    end else begin
      spec = cur_spec;
    end
    checked = (want_spec != '0) && (want_tag >= PRIVATE_TAG_MIN);
    r = '0;
    r.kind = KIND_DESC;
    r.tag = held_tag;
    r.plen = held_len;
    r.spec = spec;
    r.hit = (held_tag == want_tag) && (!checked || spec == want_spec);
    r.orphan = (held_tag >= PRIVATE_TAG_MIN) && (spec == '0);
    r.status = ST_OK;
    step_q.push_back(r);
  endtask

  task emit_status(input status_e st);
    parse_result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    step_q.push_back(r);
  endtask

  task parse_byte(input logic [7:0] b, input logic start, input logic [12:0] size,
                  input logic newl);
    logic [12:0]   sz;
    logic [11:0]   len;
    logic [12:0]   rest;
    status_e       st;
    logic          done;
    parse_result_t r;
    step_q.delete();
    done = 1'b0;
    if (start) begin
      if (newl) cur_spec = '0;
      sz = (size == '0) ? 13'd1 : size;
      area_left = sz;
      if (hdr_mode) begin
        if (sz < 13'd2) begin
          area_left = '0;
          phase = PH_IDLE;
          emit_status(ST_HDR_TRUNC);
          done = 1'b1;
        end else begin
          loop_left = '0;
          phase = PH_HDR1;
        end
      end else begin
        loop_left = sz;
        phase = PH_TAG;
      end
    end else if (phase == PH_IDLE) begin
      done = 1'b1;
    end

    if (!done) begin
      case (phase)
        PH_HDR1: begin
          loop_left = {1'b0, b[3:0], 8'h00};
          phase = PH_HDR2;
        end
        PH_HDR2: begin
          len = loop_left[11:0] | {4'h0, b};
          rest = (area_left > '0) ? area_left - 13'd1 : '0;
          if ({1'b0, len} > rest) begin
            loop_left = '0;
            phase = PH_SKIP_OVER;
          end else begin
            loop_left = {1'b0, len};
            phase = PH_TAG;
          end
        end
        PH_TAG: begin
          // with the loop used up the byte is just skipped
          if (loop_left == 13'd1) begin
            loop_left = '0;
            phase = PH_SKIP_PART;
          end else if (loop_left != '0) begin
            held_tag = b;
            loop_left = loop_left - 13'd1;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (loop_left > '0) loop_left = loop_left - 13'd1;
          held_len = b;
          collect = '0;
          collect_n = '0;
          if ({5'd0, b} > loop_left) begin
            loop_left = '0;
            phase = PH_SKIP_PART;
          end else if (b == 8'h00) begin
            emit_descriptor();
            phase = PH_TAG;
          end else begin
            pay_left = b;
            phase = PH_PAY;
          end
        end
        PH_PAY: begin
          if (loop_left > '0) loop_left = loop_left - 13'd1;
          if (collect_n < SPEC_BYTES) begin
            collect = {collect[23:0], b};
            collect_n = collect_n + 3'd1;
          end
          if (pay_left > '0) pay_left = pay_left - 8'd1;
          if (pay_left == '0) begin
            emit_descriptor();
            phase = PH_TAG;
          end
        end
        default: ;
      endcase

      if (area_left > '0) area_left = area_left - 13'd1;
      if (area_left == '0) begin
        if (phase == PH_SKIP_OVER) st = ST_LOOP_OVER;
        else if (phase == PH_TAG && loop_left == '0) st = ST_OK;
        else st = ST_PARTIAL;
        emit_status(st);
        phase = PH_IDLE;
        loop_left = '0;
      end
    end

    foreach (step_q[i]) begin
      r = step_q[i];
      r.last = (i == step_q.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t seen;
    parse_result_t want;
    if (!rst_ni) begin
      hdr_mode = RST_HEADER_MODE;
      spec_tag = RST_SPECIFIER_TAG;
      want_tag = RST_MATCH_TAG;
      want_spec = RST_MATCH_SPECIFIER;
      cur_spec = '0;
      phase = PH_IDLE;
      area_left = '0;
      loop_left = '0;
      held_tag = '0;
      held_len = '0;
      pay_left = '0;
      collect = '0;
      collect_n = '0;
      expected_q.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_HEADER_MODE:     hdr_mode = cfg_data_i[0];
          CFG_SPECIFIER_TAG:   spec_tag = cfg_data_i[7:0];
          CFG_MATCH_TAG:       want_tag = cfg_data_i[7:0];
          CFG_MATCH_SPECIFIER: want_spec = cfg_data_i[31:0];
          default: ;
        endcase
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        parse_byte(in_mon_i.data_byte, in_mon_i.area_start, in_mon_i.area_size,
                   in_mon_i.new_list);
      end

      if (out_mon_i.valid && out_mon_i.ready) begin
        seen.kind = kind_e'(out_mon_i.kind);
        seen.tag = out_mon_i.tag;
        seen.plen = out_mon_i.payload_length;
        seen.spec = out_mon_i.specifier;
        seen.hit = out_mon_i.tag_match;
        seen.orphan = out_mon_i.orphan_private;
        seen.status = status_e'(out_mon_i.status);
        seen.last = out_mon_i.last;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item: %s", fmt_result(seen));
        end else begin
          want = expected_q.pop_front();
          if (seen.kind !== want.kind || seen.tag !== want.tag || seen.plen !== want.plen ||
              seen.spec !== want.spec || seen.hit !== want.hit ||
              seen.orphan !== want.orphan || seen.status !== want.status ||
              seen.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(seen));
            end
          end
        end
      end

      pending_o <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> verif/descriptor_loop_parser_unit_tb.sv
// testbench top for descriptor_loop_parser_unit: directed areas, then random descriptor
// areas under several register settings and idle profiles; needs dlp_pkg, dlp_if, dlp_result_checker
`timescale 1ns / 1ps
module descriptor_loop_parser_unit_tb;
  import dlp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_ITEMS = 70;
  localparam int NUM_PHASES = 6;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int bytes_sent = 0;
  int areas_sent = 0;
  int areas_open = 0;
  int stray_bytes = 0;
  logic last_left_open = 1'b0;

  // register values as last written
  logic        cur_hm;
  logic [7:0]  cur_stag;
  logic [7:0]  cur_mtag;
  logic [31:0] cur_mspec;

  dlp_in_if  in_ch();
  dlp_out_if out_ch();

  descriptor_loop_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dlp_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_byte(input logic [7:0] b, input logic st, input logic [12:0] sz,
                           input logic nl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.area_start <= st;
    in_ch.area_size <= sz;
    in_ch.new_list <= nl;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // first byte carries the start flag and the declared size, the rest carry noise in the size field
  task automatic send_list(input byte_q_t seq, input logic [12:0] declared, input logic nl);
    foreach (seq[i]) begin
      send_byte(seq[i], i == 0, (i == 0) ? declared : 13'($urandom()),
                (i == 0) ? nl : 1'($urandom()));
      bytes_sent++;
    end
    areas_sent++;
  endtask

  task automatic send_area();
    byte_q_t     body;
    byte_q_t     area;
    logic [7:0]  tg;
    logic [7:0]  ln;
    logic [31:0] sv;
    logic [11:0] loop_len;
    logic [12:0] declared;
    int          ndesc;
    int          pick;
    int          extra;
    int          cut;

    // bytes outside any area are dropped by the block
    if (!last_left_open && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom()), 1'b0, 13'($urandom()), 1'($urandom()));
        stray_bytes++;
      end
    end

    ndesc = $urandom_range(0, 4);
    for (int i = 0; i < ndesc; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) tg = cur_stag;
      else if (pick < 40) tg = cur_mtag;
      else if (pick < 65) tg = 8'($urandom_range(128, 255));
      else tg = 8'($urandom());
      ln = ($urandom_range(99) < 3) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 7));
      case ($urandom_range(2))
        0: sv = cur_mspec;
        1: sv = '0;
        default: sv = $urandom();
      endcase
      body.push_back(tg);
      body.push_back(ln);
      for (int j = 0; j < ln; j++) body.push_back((j < 4) ? sv[31 - 8*j -: 8] : 8'($urandom()));
    end

    pick = $urandom_range(99);
    if (cur_hm && pick < 8) begin
      // too short for the loop length field
      area.push_back(8'($urandom()));
    end else if (cur_hm) begin
      extra = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
      loop_len = 12'(body.size());
      if (pick < 20) begin
        loop_len = 12'(body.size() + extra + $urandom_range(1, 4));
      end else if (pick < 32 && body.size() > 0) begin
        cut = (body.size() < 3) ? body.size() : 3;
        loop_len = loop_len - 12'($urandom_range(1, cut));
      end
      area.push_back({4'($urandom()), loop_len[11:8]});
      area.push_back(loop_len[7:0]);
      foreach (body[i]) area.push_back(body[i]);
      repeat (extra) area.push_back(8'($urandom()));
    end else begin
      area = body;
      if (pick < 20 && area.size() > 0) begin
        cut = (area.size() < 3) ? area.size() : 3;
        repeat ($urandom_range(1, cut)) void'(area.pop_back());
      end
      if (area.size() == 0) area.push_back(8'($urandom()));
    end

    declared = 13'(area.size());
    if (declared == 13'd1 && $urandom_range(1) == 1) declared = '0;
    last_left_open = ($urandom_range(99) < 5);
    if (last_left_open) begin
      // declared longer than sent, so the next start abandons it
      declared = 13'($urandom_range(area.size() + 1, 8191));
      areas_open++;
    end
    send_list(area, declared, $urandom_range(3) == 0);
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic hm, input logic [7:0] stag, input logic [7:0] mtag,
                              input logic [31:0] mspec);
    cfg_index_e  regs[4];
    logic [31:0] vals[4];
    regs = '{CFG_HEADER_MODE, CFG_SPECIFIER_TAG, CFG_MATCH_TAG, CFG_MATCH_SPECIFIER};
    vals = '{{31'd0, hm}, {24'd0, stag}, {24'd0, mtag}, mspec};
    cur_hm = hm;
    cur_stag = stag;
    cur_mtag = mtag;
    cur_mspec = mspec;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // output side: random stalls, plus a long hold-off when one is asked for
  initial begin
    int stretch;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        out_ch.ready <= 1'b0;
        stretch = 0;
        while (stretch < HOLD_CYCLES) begin
          @(posedge clk_i);
          stretch++;
        end
        holds_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    byte_q_t seq;
    int      phase_base;
    logic    pause_done;
    pause_done = 1'b0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.area_start <= 1'b0;
    in_ch.area_size <= '0;
    in_ch.new_list <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HEADER_MODE;
    cfg_data <= '0;
    cur_hm = RST_HEADER_MODE;
    cur_stag = RST_SPECIFIER_TAG;
    cur_mtag = RST_MATCH_TAG;
    cur_mspec = RST_MATCH_SPECIFIER;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain mode at reset values: match on tag 0, long specifier payload, private tag after it
    seq = {8'h00, 8'h00, RST_SPECIFIER_TAG, 8'h05, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h11,
           8'hFF, 8'h00};
    send_list(seq, 13'd11, 1'b1);
    // specifier payload too short, then a private tag with no specifier
    seq = {RST_SPECIFIER_TAG, 8'h02, 8'h12, 8'h34, PRIVATE_TAG_MIN, 8'h00};
    send_list(seq, 13'd6, 1'b0);
    // zero size counts as one byte: a lone tag is a split descriptor
    seq = {8'hA5};
    send_list(seq, 13'd0, 1'b0);

    drain_wait();
    apply_config(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    seq = {8'hFF};
    send_list(seq, 13'd1, 1'b0);
    // loop length larger than the area
    seq = {8'hF0, 8'h10, 8'h01};
    send_list(seq, 13'd3, 1'b0);
    // checked private match, then a byte past the loop
    seq = {8'h00, 8'h06, 8'hFF, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA};
    send_list(seq, 13'd9, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_wait();
      case (p)
        0: apply_config(1'b0, RST_SPECIFIER_TAG, 8'($urandom_range(128, 255)), 32'h0);
        1: apply_config(1'b1, 8'($urandom()), 8'($urandom_range(128, 255)), $urandom() | 32'h1);
        2: apply_config(1'b0, 8'h00, 8'h00, 32'hFFFF_FFFF);
        3: apply_config(1'b1, 8'hFF, PRIVATE_TAG_MIN, 32'h0000_0001);
        4: apply_config(1'b1, 8'($urandom()), 8'($urandom()), $urandom());
        default: apply_config(1'b0, 8'($urandom()), 8'($urandom_range(128, 255)), $urandom());
      endcase
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct = 76;
          sink_stall_pct <= 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct <= 76;
        end
        default: begin
          src_idle_pct = 24;
          sink_stall_pct <= 24;
        end
      endcase
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PHASE_ITEMS) begin
        // output held off while items keep coming, so the input backs up
        if (p == 0 && holds_asked == 0 && bytes_sent - phase_base > 15) holds_asked <= 1;
        if (p == 1 && !pause_done && bytes_sent - phase_base > 30) begin
          drain_wait();
          pause_done = 1'b1;
        end
        send_area();
      end
    end
    drain_wait();

    $display("run covered %0d area bytes in %0d areas, %0d abandoned by a restart, %0d stray bytes",
             bytes_sent, areas_sent, areas_open, stray_bytes);
    $display("plain and header modes, eight register settings, four idle profiles, one long hold");
    if (fail_count == 0 && pending == 0) begin
      $display("descriptor_loop_parser_unit regression: pass");
    end else begin
      $display("descriptor_loop_parser_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("descriptor_loop_parser_unit regression: fail");
    $finish;
  end

endmodule

>>> descriptor_loop_parser_unit.f
src/dlp_pkg.sv
src/dlp_if.sv
src/dlp_front.sv
src/dlp_queue.sv
src/dlp_back.sv
src/descriptor_loop_parser_unit.sv
verif/dlp_result_checker.sv
verif/descriptor_loop_parser_unit_tb.sv
